FILE: sv/wso_pkg.sv
// ----------------------------------------------------------------------------
// wso_pkg
// Shared types and constants of the wheel speed and odometer core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wso_pkg;

    // number of wheel lanes (1..4, as wheel_index is 2 bits); only wheels 0..3 have edge inputs
    localparam int WHEELS   = 4;
    localparam int EDGE_W   = 4;
    localparam int WIDX_W   = (WHEELS > 1) ? $clog2(WHEELS) : 1;

    // divider geometry: dividend is pulses*circ*360, divisor is ppr*dt
    localparam int DIV_W    = 41;
    localparam int DEN_W    = 24;
    localparam int DCNT_W   = $clog2(DIV_W + 1);
    localparam logic [8:0] KMH_SCALE = 9'd360;

    // configuration register indexes
    localparam logic [2:0] REG_ENABLED   = 3'd0;
    localparam logic [2:0] REG_PPR       = 3'd1;
    localparam logic [2:0] REG_CIRC      = 3'd2;
    localparam logic [2:0] REG_TIMEOUT   = 3'd3;
    localparam logic [2:0] REG_MAX_SPEED = 3'd4;
    localparam logic [2:0] REG_WINDOW    = 3'd5;

    // input item functions
    localparam logic FUNC_EDGES  = 1'b0;
    localparam logic FUNC_UPDATE = 1'b1;

    typedef struct packed {
        logic        func;
        logic [3:0]  edge_mask;
        logic [31:0] now_ms;
    } t_in;

    typedef struct packed {
        logic [1:0]  wheel_index;
        logic [15:0] speed_centi_kmh;
        logic [31:0] distance_mm;
        logic        sensor_ok;
        logic        timed_out;
        logic        last;
    } t_out;

    typedef struct packed {
        logic        enabled;
        logic [7:0]  rev_pulses;
        logic [15:0] circumference_mm;
        logic [15:0] timeout_ms;
        logic [15:0] max_speed_centi_kmh;
        logic [15:0] window_ms;
    } t_cfg;

    // per-lane status seen by the merge stage
    typedef struct packed {
        logic        busy;
        logic [15:0] speed;
        logic [31:0] odo;
        logic        alive;
        logic        tout;
    } t_lane_res;

endpackage

`default_nettype wire

FILE: sv/wso_div.sv
// ----------------------------------------------------------------------------
// wso_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wso_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [wso_pkg::DIV_W-1:0]   i_num,
    input  wire logic [wso_pkg::DEN_W-1:0]   i_den,
    output logic      [wso_pkg::DIV_W-1:0]   o_quo,
    output logic                             o_done
);

    logic [wso_pkg::DIV_W-1:0]  r_q;
    logic [wso_pkg::DEN_W-1:0]  r_rem;
    logic [wso_pkg::DEN_W-1:0]  r_den;
    logic [wso_pkg::DCNT_W-1:0] r_cnt;
    logic                       r_done;
    logic [wso_pkg::DEN_W:0]    trial;
    logic                       qbit;

    // shift in next dividend bit and try the subtract
    assign trial = {r_rem, r_q[wso_pkg::DIV_W-1]};
    assign qbit  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q   <= i_num;
                r_rem <= '0;
                r_den <= i_den;
                r_cnt <= wso_pkg::DCNT_W'(wso_pkg::DIV_W);
            end else if (r_cnt != '0) begin
                r_rem <= qbit ? wso_pkg::DEN_W'(trial - {1'b0, r_den})
                              : trial[wso_pkg::DEN_W-1:0];
                r_q   <= {r_q[wso_pkg::DIV_W-2:0], qbit};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == wso_pkg::DCNT_W'(1))
                    r_done <= 1'b1;
            end
        end
    end

    assign o_quo  = r_q;
    assign o_done = r_done;

endmodule

`default_nettype wire

FILE: sv/wso_lane.sv
// ----------------------------------------------------------------------------
// wso_lane
// One wheel: edge counter, timeout/window check, distance and speed update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wso_lane (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire wso_pkg::t_cfg     i_cfg,
    input  wire logic              i_edge,
    input  wire logic              i_update,
    input  wire logic [31:0]       i_now,
    output wso_pkg::t_lane_res     o_res
);

    typedef enum logic [2:0] {L_IDLE, L_MUL1, L_MUL2, L_DIVS, L_DIV} t_lstate;

    t_lstate     r_state;
    logic [15:0] r_cnt;
    logic [31:0] r_last_ms;
    logic [31:0] r_odo;
    logic [15:0] r_speed;
    logic        r_alive;
    logic        r_tout;
    logic [15:0] r_p;
    logic [15:0] r_dt;
    logic [31:0] r_prod;
    logic [wso_pkg::DEN_W-1:0] r_den;
    logic [wso_pkg::DIV_W-1:0] r_num;

    logic [31:0] dt;
    logic [7:0]  ppr_eff;
    logic        div_start;
    logic [wso_pkg::DIV_W-1:0] q_inc;
    logic [wso_pkg::DIV_W-1:0] q_spd;
    logic        inc_done;
    logic        spd_done;
    logic [32:0] odo_sum;

    assign dt        = i_now - r_last_ms;
    assign ppr_eff   = (i_cfg.rev_pulses == 8'd0) ? 8'd1 : i_cfg.rev_pulses;
    assign div_start = (r_state == L_DIVS);
    assign odo_sum   = {1'b0, r_odo} + {1'b0, q_inc[31:0]};

    // distance increment: pulses*circ / ppr
    wso_div u_div_inc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (wso_pkg::DIV_W'(r_prod)),
        .i_den   (wso_pkg::DEN_W'(ppr_eff)),
        .o_quo   (q_inc),
        .o_done  (inc_done)
    );

    // speed: pulses*circ*360 / (ppr*dt)
    wso_div u_div_spd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_quo   (q_spd),
        .o_done  (spd_done)
    );

    // lane sequencer and wheel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= L_IDLE;
            r_cnt     <= '0;
            r_last_ms <= '0;
            r_odo     <= '0;
            r_speed   <= '0;
            r_alive   <= 1'b1;
            r_tout    <= 1'b0;
        end else begin
            case (r_state)
                L_IDLE: begin
                    if (i_edge && r_cnt != 16'hFFFF)
                        r_cnt <= r_cnt + 16'd1;
                    if (i_update) begin
                        r_tout <= 1'b0;
                        if (!i_cfg.enabled) begin
                            r_speed <= '0;
                            r_alive <= 1'b0;
                        end else if (dt > {16'd0, i_cfg.timeout_ms}) begin
                            r_speed <= '0;
                            r_alive <= 1'b0;
                            r_tout  <= 1'b1;
                        end else if (dt >= {16'd0, i_cfg.window_ms}) begin
                            // dt is bounded by the timeout here
                            r_p       <= r_cnt;
                            r_cnt     <= '0;
                            r_dt      <= dt[15:0];
                            r_last_ms <= i_now;
                            r_state   <= L_MUL1;
                        end
                    end
                end
                L_MUL1: begin
                    r_prod  <= 32'(r_p) * 32'(i_cfg.circumference_mm);
                    r_den   <= wso_pkg::DEN_W'(ppr_eff) * wso_pkg::DEN_W'(r_dt);
                    r_state <= L_MUL2;
                end
                L_MUL2: begin
                    r_num   <= wso_pkg::DIV_W'(r_prod) * wso_pkg::DIV_W'(wso_pkg::KMH_SCALE);
                    r_state <= L_DIVS;
                end
                L_DIVS: begin
                    r_state <= L_DIV;
                end
                L_DIV: begin
                    if (inc_done && spd_done) begin
                        r_odo <= odo_sum[32] ? q_inc[31:0] : odo_sum[31:0];
                        if (r_p == '0 || r_dt == '0)
                            r_speed <= '0;
                        else if (q_spd > wso_pkg::DIV_W'(i_cfg.max_speed_centi_kmh))
                            r_speed <= i_cfg.max_speed_centi_kmh;
                        else
                            r_speed <= q_spd[15:0];
                        r_alive <= 1'b1;
                        r_state <= L_IDLE;
                    end
                end
                default: r_state <= L_IDLE;
            endcase
        end
    end

    assign o_res.busy  = (r_state != L_IDLE);
    assign o_res.speed = r_speed;
    assign o_res.odo   = r_odo;
    assign o_res.alive = r_alive;
    assign o_res.tout  = r_tout;

endmodule

`default_nettype wire

FILE: sv/wheel_speed_odometer_core.sv
// ----------------------------------------------------------------------------
// wheel_speed_odometer_core
// Four-wheel pulse counter with per-wheel distance and speed evaluation.
// ----------------------------------------------------------------------------
// An edge beat leaves the core idle. An update beat stalls the input while
// the wheel lanes evaluate, using the 41-step bit-serial dividers in each
// wheel lane (all lanes run in parallel); then the four results leave one per
// cycle, while i_stall is low, from an output register. A new beat is taken
// once the last result of an update has been delivered.
`timescale 1ns / 1ps
`default_nettype none

module wheel_speed_odometer_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [2:0]    i_cfg_idx,
    input  wire logic [15:0]   i_cfg_data,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire wso_pkg::t_in  i_data,
    output logic               o_valid,
    input  wire logic          i_stall,
    output wso_pkg::t_out      o_data
);

    typedef enum logic [1:0] {S_IDLE, S_CALC, S_EMIT} t_state;

    t_state                        r_state;
    wso_pkg::t_cfg                 r_cfg;
    logic [wso_pkg::WIDX_W-1:0]    r_idx;
    logic                          r_out_valid;
    wso_pkg::t_out                 r_out;

    wso_pkg::t_lane_res            lane_res [wso_pkg::WHEELS];
    logic [wso_pkg::WHEELS-1:0]    lane_busy;
    logic                          in_acc;
    logic                          out_acc;
    logic                          upd;
    logic [wso_pkg::WIDX_W-1:0]    sel;
    wso_pkg::t_out                 n_out;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = r_out_valid && !i_stall;
    assign upd     = in_acc && (i_data.func == wso_pkg::FUNC_UPDATE);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enabled             <= 1'b1;
            r_cfg.rev_pulses          <= 8'd6;
            r_cfg.circumference_mm    <= 16'd1000;
            r_cfg.timeout_ms          <= 16'd1000;
            r_cfg.max_speed_centi_kmh <= 16'd25000;
            r_cfg.window_ms           <= 16'd100;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                wso_pkg::REG_ENABLED:   r_cfg.enabled             <= i_cfg_data[0];
                wso_pkg::REG_PPR:       r_cfg.rev_pulses          <= i_cfg_data[7:0];
                wso_pkg::REG_CIRC:      r_cfg.circumference_mm    <= i_cfg_data;
                wso_pkg::REG_TIMEOUT:   r_cfg.timeout_ms          <= i_cfg_data;
                wso_pkg::REG_MAX_SPEED: r_cfg.max_speed_centi_kmh <= i_cfg_data;
                wso_pkg::REG_WINDOW:    r_cfg.window_ms           <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // wheel lanes
    for (genvar w = 0; w < wso_pkg::WHEELS; w++) begin : g_lane
        logic edge_hit;
        if (w < wso_pkg::EDGE_W) begin : g_edge
            assign edge_hit = in_acc && (i_data.func == wso_pkg::FUNC_EDGES)
                              && i_data.edge_mask[w];
        end else begin : g_noedge
            assign edge_hit = 1'b0;
        end

        wso_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_cfg    (r_cfg),
            .i_edge   (edge_hit),
            .i_update (upd),
            .i_now    (i_data.now_ms),
            .o_res    (lane_res[w])
        );
        assign lane_busy[w] = lane_res[w].busy;
    end

    // merge: pick the result of one wheel for the output register
    always_comb begin
        sel = (r_state == S_CALC) ? '0 : r_idx + 1'b1;
        n_out.wheel_index     = 2'(sel);
        n_out.speed_centi_kmh = lane_res[sel].speed;
        n_out.distance_mm     = lane_res[sel].odo;
        n_out.sensor_ok       = lane_res[sel].alive;
        n_out.timed_out       = lane_res[sel].tout;
        n_out.last            = (sel == wso_pkg::WIDX_W'(wso_pkg::WHEELS - 1));
    end

    // control and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (upd)
                        r_state <= S_CALC;
                end
                S_CALC: begin
                    if (lane_busy == '0) begin
                        r_out       <= n_out;
                        r_idx       <= '0;
                        r_out_valid <= 1'b1;
                        r_state     <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_acc) begin
                        if (r_out.last) begin
                            r_out_valid <= 1'b0;
                            r_state     <= S_IDLE;
                        end else begin
                            r_out <= n_out;
                            r_idx <= sel;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

`ifndef SYNTH
    a_valid_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == S_EMIT))
        else $error("result valid outside emit phase");

    a_update_starts_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd |=> (r_state == S_CALC))
        else $error("update beat did not start calculation");

    a_last_ends_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && r_out.last) |=> !o_valid)
        else $error("result after last beat of update");

    a_no_emit_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (lane_busy == '0))
        else $error("lane busy while results are sent");
`endif

endmodule

`default_nettype wire
